[hw/rtl/c2s_pkg.sv]
package c2s_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int ANGLE_W = 32;
  localparam int IN_W    = 3 * COORD_W;
  localparam int OUT_W   = COORD_W + 2 * ANGLE_W;
  localparam int PROD_W  = 2 * COORD_W;

  // cordic datapath: coordinates carry GUARD fraction bits, angles 2^AFRAC per turn
  localparam int GUARD   = 12;
  localparam int AFRAC   = 60;
  localparam int ITERS   = ANGLE_W + 8;
  localparam int CD_W    = COORD_W + GUARD + 4;
  localparam int ACC_W   = AFRAC + 2;

  // root extraction: one result bit per stage
  localparam int SQ_W    = COORD_W + GUARD;
  localparam int SQN_W   = 2 * SQ_W;
  localparam int REM_W   = SQ_W + 2;

  // latencies and output buffer
  localparam int CORD_LAT   = ITERS + 2;
  localparam int TOT_LAT    = 2 + SQ_W + CORD_LAT;
  localparam int FIFO_DEPTH = 2 ** $clog2(TOT_LAT + 2);
  localparam int FA_W       = $clog2(FIFO_DEPTH);

  localparam logic signed [ACC_W-1:0] HALF_TURN  = ACC_W'(1) << (AFRAC - 1);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (AFRAC - ANGLE_W - 1);

  // unsigned long division by shift and subtract, for the constant tables
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] part;
    int          b;
    quo  = '0;
    part = '0;
    for (b = 63; b >= 0; b--) begin
      part = {part[63:0], num[b]};
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // pi/4 with 61 fraction bits, machin formula
  function automatic logic [63:0] pi_quarter();
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] k;
    logic [63:0] s5;
    logic [63:0] s239;
    s5 = '0;
    k  = '0;
    p  = div_u64(64'd1 << 61, 64'd5);
    while (p != 64'd0) begin
      t = div_u64(p, 64'd2 * k + 64'd1);
      if (k[0]) s5 = s5 - t;
      else      s5 = s5 + t;
      p = div_u64(p, 64'd25);
      k = k + 64'd1;
    end
    s239 = '0;
    k    = '0;
    p    = div_u64(64'd1 << 61, 64'd239);
    while (p != 64'd0) begin
      t = div_u64(p, 64'd2 * k + 64'd1);
      if (k[0]) s239 = s239 - t;
      else      s239 = s239 + t;
      p = div_u64(p, 64'd57121);
      k = k + 64'd1;
    end
    return (s5 << 2) - s239;
  endfunction

  // atan(2^-idx) in turns, 2^AFRAC per turn, truncated
  function automatic logic [63:0] atan_step(input int idx);
    logic [63:0] q;
    logic [63:0] a;
    logic [63:0] t;
    logic [63:0] res;
    logic [63:0] rem;
    int          k;
    q = pi_quarter();
    if (idx == 0) begin
      a = q;
    end else begin
      a = '0;
      for (k = 0; idx * (2 * k + 1) <= 61; k++) begin
        t = div_u64(64'd1 << (61 - idx * (2 * k + 1)), 64'(2 * k + 1));
        if (k[0]) a = a - t;
        else      a = a + t;
      end
    end
    if (a >= q) begin
      res = 64'd1;
      rem = a - q;
    end else begin
      res = '0;
      rem = a;
    end
    for (k = 0; k < AFRAC - 3; k++) begin
      rem = rem << 1;
      res = res << 1;
      if (rem >= q) begin
        rem    = rem - q;
        res[0] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

[hw/rtl/cartesian_to_spherical_core.sv]
// Cartesian to spherical converter: each input beat carries a signed vector (x, y, z) and
// each output beat its radius round(sqrt(x^2+y^2+z^2)), its azimuth atan2(y, x) in [0, one turn)
// and its elevation atan2(z, rho) as a signed angle, rho being the planar radius; angles use
// 2^32 units per turn. A zero planar vector gives azimuth 0, a zero vector elevation 0. One
// vector enters per clock, and its result then passes the squares stage and the sums stage,
// 44 stages of bit-by-bit root extraction (radius and rho side by side), 42 stages of
// CORDIC vectoring (azimuth and elevation side by side), the result buffer write and the
// output register load before it is presented. The pipeline never stalls; results land in a
// 128-entry buffer and in_tready drops only while 128 accepted beats are still undelivered,
// so input keeps flowing while a result waits on out_tready.
module cartesian_to_spherical_core
  import c2s_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // x_coord, y_coord, z_coord
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // radius, azimuth, elevation
);

  localparam int SQ_LANES = 2;   // lane 0: rho, lane 1: radius

  function automatic logic signed [CD_W-1:0] scale_coord(input logic signed [COORD_W-1:0] v);
    return $signed({{(CD_W-COORD_W-GUARD){v[COORD_W-1]}}, v, {GUARD{1'b0}}});
  endfunction

  logic in_acc;
  logic out_acc;

  // beat unpacking
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;
  logic signed [COORD_W-1:0] in_z;
  logic signed [PROD_W-1:0]  in_xe;
  logic signed [PROD_W-1:0]  in_ye;
  logic signed [PROD_W-1:0]  in_ze;
  logic signed [PROD_W-1:0]  sq_x;
  logic signed [PROD_W-1:0]  sq_y;
  logic signed [PROD_W-1:0]  sq_z;

  assign in_x  = in_tdata[0*COORD_W +: COORD_W];
  assign in_y  = in_tdata[1*COORD_W +: COORD_W];
  assign in_z  = in_tdata[2*COORD_W +: COORD_W];
  assign in_xe = PROD_W'(in_x);
  assign in_ye = PROD_W'(in_y);
  assign in_ze = PROD_W'(in_z);
  assign sq_x  = in_xe * in_xe;
  assign sq_y  = in_ye * in_ye;
  assign sq_z  = in_ze * in_ze;

  // valid bit per stage
  logic [TOT_LAT-1:0] v_r;

  // stage a: squares
  logic signed [COORD_W-1:0] a_x_r, a_y_r, a_z_r;
  logic [PROD_W-1:0]         a_xx_r, a_yy_r, a_zz_r;
  logic                      a_pz_r, a_az_r;

  always_ff @(posedge clk) begin
    a_x_r  <= in_x;
    a_y_r  <= in_y;
    a_z_r  <= in_z;
    a_xx_r <= sq_x;
    a_yy_r <= sq_y;
    a_zz_r <= sq_z;
    a_pz_r <= (in_x == '0) && (in_y == '0);
    a_az_r <= (in_x == '0) && (in_y == '0) && (in_z == '0);
  end

  // stage b: planar and full sums of squares, neither overflows
  logic signed [COORD_W-1:0] b_x_r, b_y_r, b_z_r;
  logic [PROD_W-1:0]         b_pl_r, b_all_r;
  logic                      b_pz_r, b_az_r;

  always_ff @(posedge clk) begin
    b_x_r   <= a_x_r;
    b_y_r   <= a_y_r;
    b_z_r   <= a_z_r;
    b_pl_r  <= a_xx_r + a_yy_r;
    b_all_r <= a_xx_r + a_yy_r + a_zz_r;
    b_pz_r  <= a_pz_r;
    b_az_r  <= a_az_r;
  end

  // root extraction: rho = floor(sqrt(pl * 2^(2*GUARD))), r2 = floor(sqrt(4 * all))
  logic [SQN_W-1:0] sq_src [SQ_LANES];

  assign sq_src[0] = {b_pl_r, {(2*GUARD){1'b0}}};
  assign sq_src[1] = SQN_W'({b_all_r, 2'b00});

  logic [REM_W-1:0] sq_rem_r  [SQ_LANES][SQ_W-1];
  logic [SQN_W-1:0] sq_n_r    [SQ_LANES][SQ_W-1];
  logic [SQ_W-1:0]  sq_root_r [SQ_LANES][SQ_W];

  for (genvar l = 0; l < SQ_LANES; l++) begin : g_lane
    for (genvar s = 0; s < SQ_W; s++) begin : g_stage
      logic [REM_W-1:0] rem_in;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic [SQ_W-1:0]  root_in;
      logic [SQN_W-1:0] n_in;
      logic             take;

      if (s == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign n_in    = sq_src[l];
      end else begin : g_next
        assign rem_in  = sq_rem_r[l][s-1];
        assign root_in = sq_root_r[l][s-1];
        assign n_in    = sq_n_r[l][s-1];
      end

      // bring down the next two bits, try root*4+1
      assign rem_sh = {rem_in[REM_W-3:0], n_in[SQN_W-1 -: 2]};
      assign trial  = {root_in, 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clk) begin
        sq_root_r[l][s] <= {root_in[SQ_W-2:0], take};
      end

      if (s < SQ_W - 1) begin : g_carry
        always_ff @(posedge clk) begin
          sq_rem_r[l][s] <= take ? rem_sh - trial : rem_sh;
          sq_n_r[l][s]   <= {n_in[SQN_W-3:0], 2'b00};
        end
      end
    end
  end

  // coordinates and zero flags ride along the root stages
  logic signed [COORD_W-1:0] d_x_r [SQ_W];
  logic signed [COORD_W-1:0] d_y_r [SQ_W];
  logic signed [COORD_W-1:0] d_z_r [SQ_W];
  logic                      d_pz_r [SQ_W];
  logic                      d_az_r [SQ_W];

  always_ff @(posedge clk) begin
    d_x_r[0]  <= b_x_r;
    d_y_r[0]  <= b_y_r;
    d_z_r[0]  <= b_z_r;
    d_pz_r[0] <= b_pz_r;
    d_az_r[0] <= b_az_r;
    for (int k = 1; k < SQ_W; k++) begin
      d_x_r[k]  <= d_x_r[k-1];
      d_y_r[k]  <= d_y_r[k-1];
      d_z_r[k]  <= d_z_r[k-1];
      d_pz_r[k] <= d_pz_r[k-1];
      d_az_r[k] <= d_az_r[k-1];
    end
  end

  // two vectoring lanes
  logic [ANGLE_W-1:0] azimuth;
  logic [ANGLE_W-1:0] elevation;

  c2s_cordic u_az_cordic (
    .clk     (clk),
    .x_in    (scale_coord(d_x_r[SQ_W-1])),
    .y_in    (scale_coord(d_y_r[SQ_W-1])),
    .zero_in (d_pz_r[SQ_W-1]),
    .angle   (azimuth)
  );

  c2s_cordic u_el_cordic (
    .clk     (clk),
    .x_in    ($signed(CD_W'(sq_root_r[0][SQ_W-1]))),
    .y_in    (scale_coord(d_z_r[SQ_W-1])),
    .zero_in (d_az_r[SQ_W-1]),
    .angle   (elevation)
  );

  // radius = (floor(sqrt(4 * all)) + 1) / 2, held until the angles are done
  logic [COORD_W+1:0] rad_sum;
  logic [COORD_W-1:0] rd_r [CORD_LAT];

  assign rad_sum = (COORD_W+2)'(sq_root_r[1][SQ_W-1][COORD_W:0]) + (COORD_W+2)'(1);

  always_ff @(posedge clk) begin
    rd_r[0] <= rad_sum[COORD_W:1];
    for (int k = 1; k < CORD_LAT; k++) begin
      rd_r[k] <= rd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[TOT_LAT-2:0], in_acc};
    end
  end

  // result buffer; every accepted beat owns a slot, so writes never overflow
  logic [OUT_W-1:0] res_word;
  logic             res_wr;
  logic             rd_en;
  logic [OUT_W-1:0] res_mem_r [FIFO_DEPTH];
  logic [FA_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FA_W:0]    mcnt_r, mcnt_nxt;
  logic [FA_W:0]    cred_r, cred_nxt;
  logic             ov_r;
  logic [OUT_W-1:0] oq_r;

  assign res_word = {elevation, azimuth, rd_r[CORD_LAT-1]};
  assign res_wr   = v_r[TOT_LAT-1];
  assign rd_en    = (mcnt_r != '0) && (!ov_r || out_tready);

  assign in_tready  = cred_r != (FA_W+1)'(FIFO_DEPTH);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = ov_r && out_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = oq_r;

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_mem_r[wr_ptr_r] <= res_word;
    end
    if (rd_en) begin
      oq_r <= res_mem_r[rd_ptr_r];
    end
  end

  always_comb begin
    mcnt_nxt = mcnt_r;
    case ({res_wr, rd_en})
      2'b10:   mcnt_nxt = mcnt_r + 1'b1;
      2'b01:   mcnt_nxt = mcnt_r - 1'b1;
      default: mcnt_nxt = mcnt_r;
    endcase
    cred_nxt = cred_r;
    case ({in_acc, out_acc})
      2'b10:   cred_nxt = cred_r + 1'b1;
      2'b01:   cred_nxt = cred_r - 1'b1;
      default: cred_nxt = cred_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      mcnt_r   <= '0;
      cred_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      mcnt_r <= mcnt_nxt;
      cred_r <= cred_nxt;
      if (res_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        ov_r     <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/c2s_cordic.sv]
module c2s_cordic
  import c2s_pkg::*;
(
  input  logic                    clk,
  input  logic signed [CD_W-1:0]  x_in,
  input  logic signed [CD_W-1:0]  y_in,
  input  logic                    zero_in,
  output logic [ANGLE_W-1:0]      angle
);

  logic signed [CD_W-1:0]  cx_r [ITERS];
  logic signed [CD_W-1:0]  cy_r [ITERS];
  logic signed [ACC_W-1:0] ca_r [ITERS+1];
  logic                    cz_r [ITERS+1];
  logic signed [ACC_W-1:0] rnd;
  logic [ANGLE_W-1:0]      angle_r;

  // left half plane: turn by half a turn first
  always_ff @(posedge clk) begin
    if (x_in[CD_W-1]) begin
      cx_r[0] <= -x_in;
      cy_r[0] <= -y_in;
      ca_r[0] <= HALF_TURN;
    end else begin
      cx_r[0] <= x_in;
      cy_r[0] <= y_in;
      ca_r[0] <= '0;
    end
    cz_r[0] <= zero_in;
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam logic signed [ACC_W-1:0] STEP = ACC_W'(atan_step(i));
    logic up;

    assign up = !cy_r[i][CD_W-1];

    always_ff @(posedge clk) begin
      ca_r[i+1] <= up ? ca_r[i] + STEP : ca_r[i] - STEP;
      cz_r[i+1] <= cz_r[i];
    end

    if (i < ITERS - 1) begin : g_xy
      logic signed [CD_W-1:0] dx;
      logic signed [CD_W-1:0] dy;

      assign dx = cy_r[i] >>> i;
      assign dy = cx_r[i] >>> i;

      always_ff @(posedge clk) begin
        if (up) begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
        end else begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
        end
      end
    end
  end

  // round to nearest, wraps modulo one turn
  assign rnd = ca_r[ITERS] + ROUND_HALF;

  always_ff @(posedge clk) begin
    angle_r <= cz_r[ITERS] ? '0 : rnd[AFRAC-1 -: ANGLE_W];
  end

  assign angle = angle_r;

endmodule

[hw/rtl/c2s_port_chk.sv]
module c2s_port_chk
  import c2s_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // quarter turn plus an eighth of it: vectoring on tiny vectors may overshoot a little
  localparam logic signed [ANGLE_W-1:0] EL_LIM =
    (ANGLE_W'(1) << (ANGLE_W - 2)) + (ANGLE_W'(1) << (ANGLE_W - 5));

  logic [FA_W+1:0]            cnt_r;
  logic signed [ANGLE_W-1:0]  el;

  assign el = out_tdata[OUT_W-1 -: ANGLE_W];

  // beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case ({in_tvalid && in_tready, out_tvalid && out_tready})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  ap_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != '0)
    else $error("output beat without a pending input beat");

  ap_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> in_tready)
    else $error("input held off while nothing is in flight");

  ap_elev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (el >= -EL_LIM) && (el <= EL_LIM))
    else $error("elevation far beyond a quarter turn");

endmodule

bind cartesian_to_spherical_core c2s_port_chk u_port_chk (.*);
